FILE: design/lee_pkg.sv
package lee_pkg;

   localparam int LEVEL_W = 8;
   localparam int PARAM_W = 16;
   localparam int ARG_W   = 9;

   typedef enum logic [2:0] {
      MODE_NONE       = 3'd0,
      MODE_FLASH_ON   = 3'd1,
      MODE_FLASH_OFF  = 3'd2,
      MODE_CYCLE_UP   = 3'd3,
      MODE_CYCLE_DOWN = 3'd4,
      MODE_FADE_OUT   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_NEUTRAL = 3'd1,
      OP_CYCLE   = 3'd2,
      OP_FLASH   = 3'd3,
      OP_FADE    = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      REG_CH0_MIN = 3'd0,
      REG_CH0_MAX = 3'd1,
      REG_CH1_MIN = 3'd2,
      REG_CH1_MAX = 3'd3,
      REG_STEP    = 3'd4
   } reg_index_type;

   // Command as held in the input register.
   typedef struct packed {
      opcode_type           opcode;
      logic [ARG_W-1:0]     level_arg;
      logic [PARAM_W-1:0]   delay_ticks;
   } cmd_type;

   // Brightness bounds and step that apply to one channel.
   typedef struct packed {
      logic [LEVEL_W-1:0] level_min;
      logic [LEVEL_W-1:0] level_max;
      logic [LEVEL_W-1:0] level_step;
   } bounds_type;

endpackage

FILE: design/lee_channel.sv
module lee_channel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         hit,
   input  lee_pkg::cmd_type             cmd,
   input  lee_pkg::bounds_type          bounds,
   output logic                         wr_en,
   output logic [lee_pkg::LEVEL_W-1:0]  wr_level
);

   lee_pkg::mode_type               mode_ff, mode_in;
   logic [lee_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [lee_pkg::PARAM_W-1:0]     param_ff, param_in;

   logic [lee_pkg::LEVEL_W:0]       up_sum;
   logic [lee_pkg::LEVEL_W:0]       down_floor;
   logic [lee_pkg::LEVEL_W-1:0]     down_level;
   logic [lee_pkg::LEVEL_W-1:0]     half_max;
   logic                            arg_neg;

   assign up_sum     = {1'b0, level_ff} + {1'b0, bounds.level_step};
   // level - step < min is the same as level < min + step, without a sign bit.
   assign down_floor = {1'b0, bounds.level_min} + {1'b0, bounds.level_step};
   assign down_level = level_ff - bounds.level_step;
   assign half_max   = bounds.level_max >> 1;
   assign arg_neg    = cmd.level_arg[lee_pkg::ARG_W-1];

   always_comb begin
      mode_in  = mode_ff;
      level_in = level_ff;
      param_in = param_ff;
      wr_en    = 1'b0;
      wr_level = '0;
      if (en) begin
         if (cmd.opcode == lee_pkg::OP_TICK) begin
            unique case (mode_ff)
               lee_pkg::MODE_FLASH_ON: begin
                  level_in = bounds.level_max;
                  wr_en    = 1'b1;
                  wr_level = (|param_ff[lee_pkg::PARAM_W-1:lee_pkg::LEVEL_W]) ?
                             '1 : param_ff[lee_pkg::LEVEL_W-1:0];
                  mode_in  = lee_pkg::MODE_FLASH_OFF;
               end
               lee_pkg::MODE_FLASH_OFF: begin
                  level_in = bounds.level_min;
                  wr_en    = 1'b1;
                  wr_level = bounds.level_min;
                  mode_in  = lee_pkg::MODE_FLASH_ON;
               end
               lee_pkg::MODE_CYCLE_UP: begin
                  wr_en = 1'b1;
                  if (up_sum > {1'b0, bounds.level_max}) begin
                     level_in = bounds.level_max;
                     mode_in  = lee_pkg::MODE_CYCLE_DOWN;
                  end else begin
                     level_in = up_sum[lee_pkg::LEVEL_W-1:0];
                  end
                  wr_level = level_in;
               end
               lee_pkg::MODE_CYCLE_DOWN: begin
                  wr_en = 1'b1;
                  if ({1'b0, level_ff} < down_floor) begin
                     level_in = bounds.level_min;
                     mode_in  = lee_pkg::MODE_CYCLE_UP;
                  end else begin
                     level_in = down_level;
                  end
                  wr_level = level_in;
               end
               lee_pkg::MODE_FADE_OUT: begin
                  if (param_ff != '0) begin
                     param_in = param_ff - 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     if (level_ff < bounds.level_step) begin
                        level_in = '0;
                        mode_in  = lee_pkg::MODE_NONE;
                     end else begin
                        level_in = down_level;
                     end
                     wr_level = level_in;
                  end
               end
               default: begin
               end
            endcase
         end else if (hit) begin
            unique case (cmd.opcode)
               lee_pkg::OP_NEUTRAL: begin
                  mode_in = lee_pkg::MODE_NONE;
                  wr_en   = 1'b1;
               end
               lee_pkg::OP_CYCLE: begin
                  mode_in = (bounds.level_min <= level_ff) ?
                            lee_pkg::MODE_CYCLE_UP : lee_pkg::MODE_CYCLE_DOWN;
               end
               lee_pkg::OP_FLASH: begin
                  param_in = {{(lee_pkg::PARAM_W-lee_pkg::LEVEL_W){1'b0}},
                              (arg_neg ? half_max : cmd.level_arg[lee_pkg::LEVEL_W-1:0])};
                  mode_in  = (bounds.level_min < level_ff) ?
                             lee_pkg::MODE_FLASH_OFF : lee_pkg::MODE_FLASH_ON;
               end
               lee_pkg::OP_FADE: begin
                  mode_in  = lee_pkg::MODE_FADE_OUT;
                  param_in = cmd.delay_ticks;
                  level_in = arg_neg ? bounds.level_max :
                             cmd.level_arg[lee_pkg::LEVEL_W-1:0];
                  wr_en    = 1'b1;
                  wr_level = level_in;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lee_pkg::MODE_NONE;
         level_ff <= '0;
         param_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         level_ff <= level_in;
         param_ff <= param_in;
      end
   end

endmodule

FILE: design/lee_serializer.sv
module lee_serializer #(
   parameter int CHANNEL_COUNT = 2
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           load_valid,
   input  logic [CHANNEL_COUNT-1:0]                       load_mask,
   input  logic [CHANNEL_COUNT-1:0][lee_pkg::LEVEL_W-1:0] load_levels,
   output logic                                           load_ready,
   output logic                                           pending,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic                                           rsp_channel,
   output logic [lee_pkg::LEVEL_W-1:0]                    rsp_level,
   output logic                                           rsp_last
);

   localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic [CHANNEL_COUNT-1:0]                       mask_ff, mask_in;
   logic [CHANNEL_COUNT-1:0][lee_pkg::LEVEL_W-1:0] levels_ff;
   logic                                           valid_ff, valid_in;
   logic                                           channel_ff;
   logic [lee_pkg::LEVEL_W-1:0]                    level_ff;
   logic                                           last_ff;

   logic [CHANNEL_COUNT-1:0] pick_onehot;
   logic [CHANNEL_COUNT-1:0] rest;
   logic [CW-1:0]            pick_idx;
   logic                     move;

   // Results of one request leave in ascending channel order.
   assign pick_onehot = mask_ff & (~mask_ff + 1'b1);
   assign rest        = mask_ff & ~pick_onehot;

   always_comb begin
      pick_idx = '0;
      for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick_idx = CW'(i);
         end
      end
   end

   assign pending    = (mask_ff != '0);
   assign move       = pending && (!valid_ff || rsp_ready);
   assign load_ready = !pending || (move && (rest == '0));

   always_comb begin
      mask_in = mask_ff;
      if (load_valid) begin
         mask_in = load_mask;
      end else if (move) begin
         mask_in = rest;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (move) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         levels_ff <= load_levels;
      end
      if (move) begin
         channel_ff <= pick_idx[0];
         level_ff   <= levels_ff[pick_idx];
         last_ff    <= (rest == '0);
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_channel = channel_ff;
   assign rsp_level   = level_ff;
   assign rsp_last    = last_ff;

endmodule

FILE: design/led_effect_engine.sv
// A request passes through the input register, the serializer mask and output register.
// Throughput: one request per cycle while rsp_tready holds and each writes at most one
// channel; one writing n channels holds the single result port until all n are out (a
// tick: up to CHANNEL_COUNT). The next request is taken in the cycle the last result of
// the previous one moves out. Reset (synchronous, active high) sets every channel to
// mode none with level and parameter zero, and the registers to min 0, max 255, step 1.
module led_effect_engine #(
   parameter int CHANNEL_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // channel, level_arg[8:0], delay_ticks[15:0], zero fill
   input  logic [2:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_channel, pwm_level[7:0], zero fill
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wr_data
);

   logic [lee_pkg::LEVEL_W-1:0] ch0_min_ff, ch0_max_ff, ch1_min_ff, ch1_max_ff, step_ff;

   logic             in_valid_ff, in_valid_in;
   lee_pkg::cmd_type in_cmd_ff;
   logic             in_channel_ff;
   logic             in_take;
   logic             chan_sel;
   logic             req_fire;

   logic [CHANNEL_COUNT-1:0]                       wr_mask;
   logic [CHANNEL_COUNT-1:0][lee_pkg::LEVEL_W-1:0] wr_levels;
   logic                                           load_ready;
   logic                                           pending;
   logic                                           rsp_channel;
   logic [lee_pkg::LEVEL_W-1:0]                    rsp_level;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ch0_min_ff <= '0;
         ch0_max_ff <= '1;
         ch1_min_ff <= '0;
         ch1_max_ff <= '1;
         step_ff    <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (lee_pkg::reg_index_type'(csr_index))
            lee_pkg::REG_CH0_MIN: ch0_min_ff <= csr_wr_data;
            lee_pkg::REG_CH0_MAX: ch0_max_ff <= csr_wr_data;
            lee_pkg::REG_CH1_MIN: ch1_min_ff <= csr_wr_data;
            lee_pkg::REG_CH1_MAX: ch1_max_ff <= csr_wr_data;
            lee_pkg::REG_STEP:    step_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   assign req_fire   = req_tvalid && req_tready;
   assign in_take    = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff.opcode      <= lee_pkg::opcode_type'(req_tuser);
         in_cmd_ff.level_arg   <= req_tdata[9:1];
         in_cmd_ff.delay_ticks <= req_tdata[25:10];
         in_channel_ff         <= req_tdata[0];
      end
   end

   // A command to a channel that does not exist goes to channel 0.
   assign chan_sel = (CHANNEL_COUNT > 1) ? in_channel_ff : 1'b0;

   for (genvar k = 0; k < CHANNEL_COUNT; k++) begin : g_chan
      localparam bit KBIT = (k == 1);
      lee_pkg::bounds_type bounds;
      logic                hit;

      if (k == 0) begin : g_b0
         assign bounds.level_min = ch0_min_ff;
         assign bounds.level_max = ch0_max_ff;
      end else begin : g_b1
         assign bounds.level_min = ch1_min_ff;
         assign bounds.level_max = ch1_max_ff;
      end
      assign bounds.level_step = step_ff;
      assign hit = (k < 2) && (chan_sel == KBIT);

      lee_channel u_channel (
         .clock    (clock),
         .reset    (reset),
         .en       (in_take),
         .hit      (hit),
         .cmd      (in_cmd_ff),
         .bounds   (bounds),
         .wr_en    (wr_mask[k]),
         .wr_level (wr_levels[k])
      );
   end

   lee_serializer #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_serializer (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (in_take),
      .load_mask   (wr_mask),
      .load_levels (wr_levels),
      .load_ready  (load_ready),
      .pending     (pending),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_channel (rsp_channel),
      .rsp_level   (rsp_level),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, rsp_level, rsp_channel};

   // A fade-out request always leaves one write behind it.
   a_fade_writes: assert property (@(posedge clock) disable iff (reset)
      (in_take && (in_cmd_ff.opcode == lee_pkg::OP_FADE)) |=> pending)
      else $error("fade-out request produced no write");

   // A result that is not the last one of its request has more waiting behind it.
   a_more_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> pending)
      else $error("non-final result with nothing pending");

   // Unused opcodes produce no result.
   a_unused_quiet: assert property (@(posedge clock) disable iff (reset)
      (in_take && (in_cmd_ff.opcode != lee_pkg::OP_TICK)
               && (in_cmd_ff.opcode != lee_pkg::OP_NEUTRAL)
               && (in_cmd_ff.opcode != lee_pkg::OP_CYCLE)
               && (in_cmd_ff.opcode != lee_pkg::OP_FLASH)
               && (in_cmd_ff.opcode != lee_pkg::OP_FADE)) |=> !pending)
      else $error("unused opcode produced a write");

endmodule

FILE: dv/tb_led_effect_engine.sv
module tb_led_effect_engine;

   localparam int CHANNELS = 2;
   localparam int STALL_LIMIT = 4000;
   localparam int IDLE_PCT = 29;
   localparam int RANDOM_PER_PHASE = 180;
   localparam int DIRECTED_ROWS = 25;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic [8:0] ARG_DEFAULT = 9'h1FF;

   typedef struct {
      bit       chan;
      bit [7:0] level;
      bit       last;
   } pwm_write_type;

   // One row of the directed part; expectations are typed in only where typed is set.
   typedef struct packed {
      logic [2:0]  op;
      bit          ch;
      logic [8:0]  arg;
      bit [15:0]   dly;
      bit          typed;
      bit          typed_writes;
      bit          typed_ch;
      bit [7:0]    typed_lvl;
   } stim_row_type;

   typedef struct packed {
      bit [7:0] min0;
      bit [7:0] max0;
      bit [7:0] min1;
      bit [7:0] max1;
      bit [7:0] step;
   } bounds_setting_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = lee_pkg::OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = lee_pkg::REG_CH0_MIN;
   logic [7:0]  csr_wr_data = '0;

   // Model of the engine state and its registers.
   lee_pkg::mode_type chan_mode [CHANNELS];
   bit [7:0]    chan_level [CHANNELS];
   bit [15:0]   chan_param [CHANNELS];
   bit [7:0]    level_min [CHANNELS];
   bit [7:0]    level_max [CHANNELS];
   bit [7:0]    level_step;

   pwm_write_type new_writes [$];
   pwm_write_type expected_writes [$];
   bit          idle_enable = 1'b1;
   int          mismatch_count = 0;
   int          request_count = 0;
   int          write_count = 0;
   int          setting_count = 0;
   int          stall_cycles = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_NEUTRAL, 1'b0, 9'd0,        16'd0,    1'b1, 1'b1, 1'b0, 8'd0},
      '{lee_pkg::OP_NEUTRAL, 1'b1, 9'd0,        16'd0,    1'b1, 1'b1, 1'b1, 8'd0},
      '{lee_pkg::OP_FADE,    1'b0, ARG_DEFAULT, 16'd0,    1'b1, 1'b1, 1'b0, 8'd255},
      '{lee_pkg::OP_FADE,    1'b1, 9'd255,      16'hFFFF, 1'b1, 1'b1, 1'b1, 8'd255},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_FADE,    1'b0, 9'd0,        16'd0,    1'b1, 1'b1, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b1, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_NEUTRAL, 1'b1, 9'd0,        16'd0,    1'b1, 1'b1, 1'b1, 8'd0},
      '{lee_pkg::OP_FLASH,   1'b0, ARG_DEFAULT, 16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_FLASH,   1'b1, 9'd255,      16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_CYCLE,   1'b0, 9'd0,        16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_CYCLE,   1'b1, 9'd0,        16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_FLASH,   1'b0, 9'd0,        16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{OP_UNUSED_LO,        1'b1, ARG_DEFAULT, 16'hFFFF, 1'b1, 1'b0, 1'b0, 8'd0},
      '{OP_UNUSED_HI,        1'b0, 9'd0,        16'd0,    1'b1, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_TICK,    1'b0, 9'd0,        16'd0,    1'b0, 1'b0, 1'b0, 8'd0},
      '{lee_pkg::OP_NEUTRAL, 1'b0, 9'd0,        16'd0,    1'b1, 1'b1, 1'b0, 8'd0},
      '{lee_pkg::OP_NEUTRAL, 1'b1, 9'd0,        16'd0,    1'b1, 1'b1, 1'b1, 8'd0}
   };

   // Settings for the random phases; in slots 4 and 6 every field is replaced at random, with a step of at least 1.
   bounds_setting_type phase_settings [7] = '{
      '{8'd0,   8'd255, 8'd0,   8'd255, 8'd255},
      '{8'd200, 8'd50,  8'd255, 8'd0,   8'd7},
      '{8'd10,  8'd240, 8'd100, 8'd100, 8'd3},
      '{8'd0,   8'd255, 8'd30,  8'd60,  8'd0},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd1},
      '{8'd255, 8'd255, 8'd0,   8'd0,   8'd128},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd1}
   };

   led_effect_engine #(.CHANNEL_COUNT(CHANNELS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Steps one channel on a tick; returns 1 when the channel writes its PWM.
   function automatic bit advance_channel(input int c, output bit [7:0] lvl);
      int v;
      int mn;
      int mx;
      v = chan_level[c];
      mn = level_min[c];
      mx = level_max[c];
      lvl = '0;
      case (chan_mode[c])
         lee_pkg::MODE_FLASH_ON: begin
            chan_level[c] = mx[7:0];
            lvl = (chan_param[c] > 16'd255) ? 8'hFF : chan_param[c][7:0];
            chan_mode[c] = lee_pkg::MODE_FLASH_OFF;
            return 1'b1;
         end
         lee_pkg::MODE_FLASH_OFF: begin
            chan_level[c] = mn[7:0];
            lvl = mn[7:0];
            chan_mode[c] = lee_pkg::MODE_FLASH_ON;
            return 1'b1;
         end
         lee_pkg::MODE_CYCLE_UP: begin
            v = v + level_step;
            if (v > mx) begin
               v = mx;
               chan_mode[c] = lee_pkg::MODE_CYCLE_DOWN;
            end
            chan_level[c] = v[7:0];
            lvl = v[7:0];
            return 1'b1;
         end
         lee_pkg::MODE_CYCLE_DOWN: begin
            v = v - level_step;
            if (v < mn) begin
               v = mn;
               chan_mode[c] = lee_pkg::MODE_CYCLE_UP;
            end
            chan_level[c] = v[7:0];
            lvl = v[7:0];
            return 1'b1;
         end
         lee_pkg::MODE_FADE_OUT: begin
            // The delay runs down silently before the level starts to drop.
            if (chan_param[c] != 16'd0) begin
               chan_param[c] = chan_param[c] - 16'd1;
               return 1'b0;
            end
            v = v - level_step;
            if (v < 0) begin
               v = 0;
               chan_mode[c] = lee_pkg::MODE_NONE;
            end
            chan_level[c] = v[7:0];
            lvl = v[7:0];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Fills new_writes with the PWM writes that one request causes.
   function automatic void predict_pwm_writes(input logic [2:0] op, input bit ch,
                                              input logic [8:0] arg, input bit [15:0] dly);
      bit [7:0] lvl;
      int       a;
      new_writes.delete();
      case (op)
         lee_pkg::OP_TICK: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (advance_channel(c, lvl))
                  new_writes.push_back('{chan: c[0], level: lvl, last: 1'b0});
            end
         end
         lee_pkg::OP_NEUTRAL: begin
            chan_mode[ch] = lee_pkg::MODE_NONE;
            new_writes.push_back('{chan: ch, level: 8'd0, last: 1'b0});
         end
         lee_pkg::OP_CYCLE: begin
            chan_mode[ch] = (level_min[ch] <= chan_level[ch]) ?
                            lee_pkg::MODE_CYCLE_UP : lee_pkg::MODE_CYCLE_DOWN;
         end
         lee_pkg::OP_FLASH: begin
            a = arg[8] ? level_max[ch] / 2 : arg[7:0];
            chan_param[ch] = a[15:0];
            chan_mode[ch] = (level_min[ch] < chan_level[ch]) ?
                            lee_pkg::MODE_FLASH_OFF : lee_pkg::MODE_FLASH_ON;
         end
         lee_pkg::OP_FADE: begin
            chan_mode[ch] = lee_pkg::MODE_FADE_OUT;
            chan_param[ch] = dly;
            chan_level[ch] = arg[8] ? level_max[ch] : arg[7:0];
            new_writes.push_back('{chan: ch, level: chan_level[ch], last: 1'b0});
         end
         default: ;
      endcase
      if (new_writes.size() > 0)
         new_writes[new_writes.size() - 1].last = 1'b1;
   endfunction

   task automatic send_request(input logic [2:0] op, input bit ch, input logic [8:0] arg,
                               input bit [15:0] dly, input bit typed, input bit typed_writes,
                               input bit typed_ch, input bit [7:0] typed_lvl);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, dly, arg, ch};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_pwm_writes(op, ch, arg, dly);
      if (typed) begin
         if (typed_writes)
            expected_writes.push_back('{chan: typed_ch, level: typed_lvl, last: 1'b1});
      end else begin
         foreach (new_writes[i])
            expected_writes.push_back(new_writes[i]);
      end
      request_count++;
   endtask

   task automatic random_request(output logic [2:0] op, output bit ch, output logic [8:0] arg,
                                 output bit [15:0] dly);
      int r;
      r = $urandom_range(99);
      if (r < 45)      op = lee_pkg::OP_TICK;
      else if (r < 53) op = lee_pkg::OP_NEUTRAL;
      else if (r < 68) op = lee_pkg::OP_CYCLE;
      else if (r < 83) op = lee_pkg::OP_FLASH;
      else if (r < 97) op = lee_pkg::OP_FADE;
      else             op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      ch = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 15)      arg = ARG_DEFAULT;
      else if (r < 20) arg = 9'd255;
      else if (r < 25) arg = 9'd0;
      else             arg = 9'($urandom_range(255));
      // Short delays let fades finish; a few long ones keep a channel parked.
      r = $urandom_range(99);
      if (r < 60)      dly = 16'($urandom_range(3));
      else if (r < 90) dly = 16'($urandom_range(40, 4));
      else if (r < 95) dly = 16'hFFFF;
      else             dly = 16'($urandom_range(65535));
   endtask

   task automatic write_csr(input logic [2:0] idx, input bit [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input bounds_setting_type s);
      write_csr(REG_UNUSED, 8'($urandom_range(255)));
      write_csr(lee_pkg::REG_CH0_MIN, s.min0);
      write_csr(lee_pkg::REG_CH0_MAX, s.max0);
      write_csr(lee_pkg::REG_CH1_MIN, s.min1);
      write_csr(lee_pkg::REG_CH1_MAX, s.max1);
      write_csr(lee_pkg::REG_STEP, s.step);
      csr_wr_en <= 1'b0;
      level_min[0] = s.min0;
      level_max[0] = s.max0;
      level_min[1] = s.min1;
      level_max[1] = s.max1;
      level_step = s.step;
      setting_count++;
   endtask

   // Registers change only once every expected write has drained and the engine has then idled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      pwm_write_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         write_count++;
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected PWM write chan=%0d level=%0d last=%0b", $time,
                     rsp_tdata[0], rsp_tdata[8:1], rsp_tlast);
            mismatch_count++;
         end else begin
            exp = expected_writes.pop_front();
            if (rsp_tdata[0] !== exp.chan) begin
               $display("%0t: out_channel expected %0d actual %0d", $time, exp.chan,
                        rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[8:1] !== exp.level) begin
               $display("%0t: pwm_level expected %0d actual %0d", $time, exp.level,
                        rsp_tdata[8:1]);
               mismatch_count++;
            end
            if (rsp_tlast !== exp.last) begin
               $display("%0t: last expected %0b actual %0b", $time, exp.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or write accepted for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [2:0]         op;
      bit                 ch;
      logic [8:0]         arg;
      bit [15:0]          dly;
      bounds_setting_type s;

      for (int c = 0; c < CHANNELS; c++) begin
         chan_mode[c] = lee_pkg::MODE_NONE;
         chan_level[c] = '0;
         chan_param[c] = '0;
         level_min[c] = 8'd0;
         level_max[c] = 8'd255;
      end
      level_step = 8'd1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].arg,
                      directed_rows[i].dly, directed_rows[i].typed,
                      directed_rows[i].typed_writes, directed_rows[i].typed_ch,
                      directed_rows[i].typed_lvl);

      foreach (phase_settings[p]) begin
         wait_drained();
         s = phase_settings[p];
         if (p == 4 || p == 6) begin
            s.min0 = 8'($urandom_range(255));
            s.max0 = 8'($urandom_range(255));
            s.min1 = 8'($urandom_range(255));
            s.max1 = 8'($urandom_range(255));
            s.step = 8'($urandom_range(255, 1));
         end
         apply_settings(s);
         // One phase runs with both sides always ready.
         idle_enable = (p != 2);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            random_request(op, ch, arg, dly);
            send_request(op, ch, arg, dly, 1'b0, 1'b0, 1'b0, 8'd0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests (%0d directed) over %0d register settings,", request_count,
               DIRECTED_ROWS, setting_count);
      $display("and checked %0d PWM writes; %0d mismatches.", write_count, mismatch_count);
      if (mismatch_count == 0 && expected_writes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
